FILE: rtl/scc_pkg.sv
// Package for the stack calculator core: opcodes, status codes and item types.
// Used by every module in rtl; depends on nothing.
package scc_pkg;

  localparam int StackDepth = 10;
  localparam int SpW = $clog2(StackDepth + 1);
  localparam int IdxW = $clog2(StackDepth);

  typedef enum logic [3:0] {
    OP_PUSH = 4'd0, OP_PUSHR = 4'd1, OP_PLUS = 4'd2, OP_NEG = 4'd3, OP_RET = 4'd4,
    OP_ADD = 4'd5, OP_SUB = 4'd6, OP_MUL = 4'd7, OP_DIV = 4'd8, OP_MOD = 4'd9,
    OP_POW = 4'd10
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_UNDER = 3'd1, ST_OVER = 3'd2, ST_DIVZ = 3'd3, ST_BADOP = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CL_NOP, CL_PUSH, CL_NEG, CL_RET
  } unary_e;

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] immediate;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] top_value;
    logic [3:0]         stack_count;
    logic signed [31:0] program_value;
    logic               returned;
  } out_item_t;

  // Classified instruction passed from the front end to the execute unit.
  typedef struct packed {
    logic        bad;
    logic        binary;
    opcode_e     op;
    logic [31:0] imm;
  } cmd_t;

  typedef enum logic [2:0] {
    EX_IDLE, EX_RD, EX_ITER, EX_MUL, EX_DONE
  } ex_state_e;

endpackage

FILE: rtl/scc_front.sv
// Front end of the stack calculator: accepts instructions, classifies them
// and holds them in a two-entry queue. Depends on scc_pkg.
module scc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_ready,
  input  scc_pkg::in_item_t in_data,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output scc_pkg::cmd_t     cmd_o
);
  import scc_pkg::*;

  cmd_t       q_mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  cmd_t       cls;
  logic       push, pop;

  always_comb begin
    cls.imm    = in_data.immediate;
    cls.op     = opcode_e'(in_data.func);
    cls.bad    = (in_data.func > 4'd10);
    cls.binary = (in_data.func >= 4'd5) && !cls.bad;
  end

  assign in_ready    = (cnt_q != 2'd2);
  assign push        = in_valid && in_ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wp_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: rtl/scc_divpow.sv
// Iterative arithmetic unit: 32-step restoring divide and square-and-multiply
// power, one step per cycle. Depends on scc_pkg.
module scc_divpow (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        pow_i,
  input  logic [31:0] l_i,
  input  logic [31:0] r_i,
  output logic        done_o,
  output logic [31:0] quo_o,
  output logic [31:0] rem_o,
  output logic [31:0] pow_o
);
  import scc_pkg::*;

  logic        busy_q, pow_q;
  logic [5:0]  cnt_q;
  logic [31:0] a_q, b_q, r_q, acc_q;
  logic [32:0] trial;
  logic [31:0] rsh;

  assign rsh   = {r_q[30:0], a_q[31]};
  assign trial = {1'b0, rsh} - {1'b0, b_q};
  assign done_o = busy_q && (cnt_q == 6'd32);
  assign quo_o = a_q;
  assign rem_o = r_q;
  assign pow_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == 6'd32) busy_q <= 1'b0;
      else cnt_q <= cnt_q + 6'd1;
    end
  end

  // For power, a_q holds the base, b_q the exponent shifted right each step.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      pow_q <= pow_i;
      acc_q <= 32'd1;
      r_q   <= '0;
      if (pow_i) begin
        a_q <= l_i;
        b_q <= r_i;
      end else begin
        a_q <= l_i[31] ? 32'd0 - l_i : l_i;
        b_q <= r_i[31] ? 32'd0 - r_i : r_i;
      end
    end else if (busy_q && cnt_q != 6'd32) begin
      if (pow_q) begin
        if (b_q[0]) acc_q <= acc_q * a_q;
        a_q <= a_q * a_q;
        b_q <= b_q >> 1;
      end else if (!trial[32]) begin
        r_q <= trial[31:0];
        a_q <= {a_q[30:0], 1'b1};
      end else begin
        r_q <= rsh;
        a_q <= {a_q[30:0], 1'b0};
      end
    end
  end
endmodule

FILE: rtl/scc_exec.sv
// Execute unit of the stack calculator: operand stack, result register and
// the instruction sequencer. Depends on scc_pkg and scc_divpow.
module scc_exec (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  scc_pkg::cmd_t      cmd_i,
  output logic               out_valid,
  input  logic               out_ready,
  output scc_pkg::out_item_t out_data
);
  import scc_pkg::*;

  logic [31:0]    stk_q [StackDepth];
  logic [SpW-1:0] sp_q, sp_d;
  logic [31:0]    ret_q;
  ex_state_e      st_q, st_d;
  cmd_t           cmd_q;
  logic [31:0]    l_q, r_q, res;
  logic           ov_q;
  out_item_t      out_q;

  logic           du_start, du_done;
  logic [31:0]    quo, rem, pw;
  logic [2:0]     status;
  logic           wr_en, ret_en, fault;
  logic [SpW-1:0] wr_sp;
  logic [31:0]    wr_val;
  logic           use_unit;

  scc_divpow u_divpow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (du_start),
    .pow_i   (cmd_q.op == OP_POW),
    .l_i     (l_q),
    .r_i     (r_q),
    .done_o  (du_done),
    .quo_o   (quo),
    .rem_o   (rem),
    .pow_o   (pw)
  );

  assign cmd_ready_o = (st_q == EX_IDLE) && (!ov_q || out_ready);
  assign out_valid   = ov_q;
  assign out_data    = out_q;
  assign use_unit    = (cmd_q.op == OP_DIV) || (cmd_q.op == OP_MOD) ||
                       ((cmd_q.op == OP_POW) && !r_q[31]);

  always_comb begin
    res = '0;
    fault = 1'b0;
    unique case (cmd_q.op)
      OP_ADD: res = l_q + r_q;
      OP_SUB: res = l_q - r_q;
      OP_DIV: begin
        fault = (r_q == '0);
        res = (l_q[31] != r_q[31]) ? 32'd0 - quo : quo;
      end
      OP_MOD: begin
        fault = (r_q == '0);
        res = l_q[31] ? 32'd0 - rem : rem;
      end
      OP_POW: begin
        if (!r_q[31]) res = pw;
        else if (l_q == 32'd1) res = 32'd1;
        else if (l_q == '1) res = r_q[0] ? '1 : 32'd1;
        else begin
          res = '0;
          fault = (l_q == '0);
        end
      end
      default: res = '0;
    endcase
  end

  always_comb begin
    st_d     = st_q;
    sp_d     = sp_q;
    du_start = 1'b0;
    wr_en    = 1'b0;
    ret_en   = 1'b0;
    wr_sp    = sp_q;
    wr_val   = cmd_q.imm;
    status   = ST_OK;
    unique case (st_q)
      EX_IDLE: begin
        if (cmd_valid_i && cmd_ready_o) st_d = EX_RD;
      end
      EX_RD: begin
        if (cmd_q.bad) begin
          status = ST_BADOP;
          st_d = EX_DONE;
        end else if (!cmd_q.binary) begin
          st_d = EX_DONE;
          priority case (1'b1)
            cmd_q.op == OP_PUSH: begin
              if (sp_q >= SpW'(StackDepth)) status = ST_OVER;
              else begin
                wr_en = 1'b1;
                sp_d = sp_q + 1'b1;
              end
            end
            cmd_q.op == OP_NEG: begin
              if (sp_q == '0) status = ST_UNDER;
              else begin
                wr_en = 1'b1;
                wr_sp = sp_q - 1'b1;
                wr_val = 32'd0 - l_q;
              end
            end
            cmd_q.op == OP_RET: begin
              if (sp_q == '0) status = ST_UNDER;
              else begin
                ret_en = 1'b1;
                sp_d = sp_q - 1'b1;
              end
            end
            default: status = ST_OK;
          endcase
        end else if (sp_q < SpW'(2)) begin
          status = ST_UNDER;
          st_d = EX_DONE;
        end else if (use_unit && ((cmd_q.op == OP_POW) || (r_q != '0))) begin
          du_start = 1'b1;
          st_d = EX_ITER;
        end else st_d = EX_MUL;
      end
      EX_ITER: begin
        if (du_done) st_d = EX_MUL;
      end
      EX_MUL: begin
        st_d = EX_DONE;
        if (cmd_q.op == OP_MUL) wr_val = l_q * r_q;
        else wr_val = res;
        if (fault && cmd_q.op != OP_MUL) status = ST_DIVZ;
        else begin
          wr_en = 1'b1;
          wr_sp = sp_q - SpW'(2);
          sp_d = sp_q - 1'b1;
        end
      end
      EX_DONE: st_d = EX_IDLE;
      default: st_d = EX_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= EX_IDLE;
      sp_q  <= '0;
      ret_q <= '1;
      ov_q  <= 1'b0;
    end else begin
      st_q <= st_d;
      sp_q <= sp_d;
      if (ret_en) ret_q <= l_q;
      if (st_q == EX_DONE) ov_q <= 1'b1;
      else if (ov_q && out_ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == EX_IDLE && cmd_valid_i && cmd_ready_o) cmd_q <= cmd_i;
    if (st_q == EX_IDLE) begin
      l_q <= (sp_q != '0) ? stk_q[IdxW'(sp_q - 1'b1)] : '0;
      r_q <= (sp_q > SpW'(1)) ? stk_q[IdxW'(sp_q - SpW'(2))] : '0;
    end
    if (wr_en) stk_q[IdxW'(wr_sp)] <= wr_val;
    if (st_q == EX_RD || st_q == EX_MUL) begin
      out_q.status <= status;
      out_q.returned <= ret_en;
    end
    if (st_q == EX_DONE) begin
      out_q.stack_count <= 4'(sp_q);
      out_q.top_value <= (sp_q != '0) ? stk_q[IdxW'(sp_q - 1'b1)] : '0;
      out_q.program_value <= ret_q;
    end
  end
endmodule

FILE: rtl/stack_calculator_core.sv
// Stack calculator core top level: front-end queue plus execute unit.
// Sequencing: push, return, negate, no-ops and bad opcodes pass through the read
// and done states; add, sub, mul, divide by zero and negative-exponent pow also pass
// the write-back state; div, mod and pow further wait on the 32-step shared divide
// and power unit. One item in execution; a new item is taken only when idle.
// Reset: asynchronous, active low; empties the stack and sets the result to -1.
module stack_calculator_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_ready,
  input  scc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output scc_pkg::out_item_t out_data
);
  import scc_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  scc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  scc_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );
endmodule

FILE: tb/sv/tb_stack_calculator_core.sv
// Testbench for stack_calculator_core: drives instruction items, predicts each
// result with a behavioral stack machine and compares field by field.
// Depends on scc_pkg and the stack_calculator_core RTL.
`timescale 1ns / 100ps

module tb_stack_calculator_core;
  import scc_pkg::*;

  localparam int WatchdogLimit = 20000;

  class calc_scoreboard;
    logic [31:0]  stack_mem [StackDepth];
    int           depth;
    logic [31:0]  last_ret;
    out_item_t    pending [$];
    int           errors;
    int           checked;

    function new();
      depth = 0;
      last_ret = 32'hFFFF_FFFF;
      errors = 0;
      checked = 0;
    endfunction

    function logic [31:0] power(logic [31:0] b, logic [31:0] e, output bit fault);
      logic [31:0] acc;
      acc = 32'd1;
      fault = 1'b0;
      if (e[31]) begin
        if (b == 32'd1) return 32'd1;
        if (b == 32'hFFFF_FFFF) return e[0] ? 32'hFFFF_FFFF : 32'd1;
        if (b == 32'd0) fault = 1'b1;
        return 32'd0;
      end
      while (e != 0) begin
        if (e[0]) acc = acc * b;
        b = b * b;
        e = e >> 1;
      end
      return acc;
    endfunction

    function void note_instruction(in_item_t it);
      out_item_t   r;
      status_e     st;
      logic [31:0] lhs, rhs, res, la, ra, q, m;
      bit          fault;
      st = ST_OK;
      r.returned = 1'b0;
      fault = 1'b0;
      res = '0;
      if (it.func == OP_PUSH) begin
        if (depth >= StackDepth) st = ST_OVER;
        else begin
          stack_mem[depth] = it.immediate;
          depth++;
        end
      end else if (it.func == OP_PUSHR || it.func == OP_PLUS) begin
      end else if (it.func == OP_NEG) begin
        if (depth == 0) st = ST_UNDER;
        else stack_mem[depth-1] = -stack_mem[depth-1];
      end else if (it.func == OP_RET) begin
        if (depth == 0) st = ST_UNDER;
        else begin
          depth--;
          last_ret = stack_mem[depth];
          r.returned = 1'b1;
        end
      end else if (it.func <= OP_POW) begin
        if (depth < 2) st = ST_UNDER;
        else begin
          lhs = stack_mem[depth-1];
          rhs = stack_mem[depth-2];
          case (it.func)
            OP_ADD: res = lhs + rhs;
            OP_SUB: res = lhs - rhs;
            OP_MUL: res = lhs * rhs;
            OP_DIV, OP_MOD: begin
              if (rhs == 0) fault = 1'b1;
              else begin
                la = lhs[31] ? -lhs : lhs;
                ra = rhs[31] ? -rhs : rhs;
                q = la / ra;
                m = la % ra;
                if (it.func == OP_DIV) res = (lhs[31] != rhs[31]) ? -q : q;
                else res = lhs[31] ? -m : m;
              end
            end
            default: res = power(lhs, rhs, fault);
          endcase
          if (fault) st = ST_DIVZ;
          else begin
            depth--;
            stack_mem[depth-1] = res;
          end
        end
      end else st = ST_BADOP;
      r.status = st;
      r.top_value = depth ? stack_mem[depth-1] : 32'd0;
      r.stack_count = depth[3:0];
      r.program_value = last_ret;
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending.size() == 0) begin
        $error("result with no expectation: %p", got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (got.status !== exp_r.status) begin
        $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
      end
      if (got.top_value !== exp_r.top_value) begin
        $error("top_value exp %0d got %0d", exp_r.top_value, got.top_value); errors++;
      end
      if (got.stack_count !== exp_r.stack_count) begin
        $error("stack_count exp %0d got %0d", exp_r.stack_count, got.stack_count);
        errors++;
      end
      if (got.program_value !== exp_r.program_value) begin
        $error("program_value exp %0d got %0d", exp_r.program_value, got.program_value);
        errors++;
      end
      if (got.returned !== exp_r.returned) begin
        $error("returned exp %0d got %0d", exp_r.returned, got.returned); errors++;
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  calc_scoreboard sb = new();
  int  idle_cycles = 0;
  int  sent = 0;
  bit  hold_sink = 1'b0;
  bit  sink_stalled = 1'b0;
  int  model_depth = 0;

  always #4 clk_i = ~clk_i;

  stack_calculator_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) sb.note_instruction(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog expired");
        $display("FAIL stack_calculator_core");
        $finish;
      end
    end
  end

  // Receiver: random stalls per item, plus one long hold-off on request.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        out_ready <= 1'b0;
        sink_stalled = 1'b1;
        repeat (300) @(negedge clk_i);
        hold_sink = 1'b0;
        sink_stalled = 1'b0;
      end
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!(out_valid && out_ready));
    end
  end

  task automatic send_item(logic [3:0] op, logic [31:0] imm, bit no_gap);
    int n;
    n = no_gap ? 0 : $urandom_range(0, 10);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    in_data <= '{func: op, immediate: imm};
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    sent++;
    case (op)
      OP_PUSH: if (model_depth < StackDepth) model_depth++;
      OP_RET: if (model_depth > 0) model_depth--;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_POW:
        if (model_depth >= 2) model_depth--;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(0, 3);
      4: return -$urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  initial begin
    logic [3:0] op;
    int k;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // Directed: empty-stack underflow, no-ops, bad opcode, extremes.
    send_item(OP_RET, 0, 0);
    send_item(OP_NEG, 0, 0);
    send_item(OP_ADD, 0, 0);
    send_item(OP_PLUS, 0, 0);
    send_item(OP_PUSHR, 0, 0);
    send_item(4'd15, 0, 0);
    send_item(4'd11, 0, 0);
    send_item(OP_PUSH, 32'hFFFF_FFFF, 0);
    send_item(OP_PUSH, 32'h8000_0000, 0);
    send_item(OP_DIV, 0, 0);
    send_item(OP_PUSH, 32'h8000_0000, 0);
    send_item(OP_MOD, 0, 0);
    send_item(OP_PUSH, 0, 0);
    send_item(OP_DIV, 0, 0);
    send_item(OP_POW, 0, 0);
    send_item(OP_NEG, 0, 0);
    send_item(OP_RET, 0, 0);
    send_item(OP_PUSH, 32'h7FFF_FFFF, 0);
    send_item(OP_PUSH, 0, 0);
    send_item(OP_POW, 0, 0);
    for (k = 0; k < 10; k++) send_item(OP_PUSH, k + 3, 1);
    send_item(OP_MUL, 0, 0);
    send_item(OP_SUB, 0, 0);
    // Fill the block while the receiver holds off.
    hold_sink = 1'b1;
    for (k = 0; k < 12; k++) send_item(OP_PLUS, 0, 1);
    in_valid <= 1'b0;
    while (hold_sink) @(negedge clk_i);
    // Sender pause until every expected result is in.
    drain();
    // Random programs: mostly well-formed operations, some noise.
    while (sent < 575) begin
      k = $urandom_range(0, 99);
      if (k < 3) op = 4'(11 + $urandom_range(0, 4));
      else if (k < 8) op = 4'($urandom_range(1, 2));
      else if (model_depth < 2 && k < 70) op = OP_PUSH;
      else if (model_depth >= StackDepth - 1 && k < 80) op = 4'($urandom_range(3, 10));
      else if (k < 40) op = OP_PUSH;
      else op = 4'($urandom_range(3, 10));
      send_item(op, pick_value(), $urandom_range(0, 4) == 0);
    end
    drain();
    $display("Ran %0d instruction items, %0d results checked, including overflow,",
             sent, sb.checked);
    $display("underflow, divide-by-zero, bad opcode and a long output stall.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS stack_calculator_core");
    end else begin
      $display("FAIL stack_calculator_core");
    end
    $finish;
  end
endmodule
